@@ hdl/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8_pkg: shared types, constants and helpers
// Request payloads, queue entry layout and the UTF-8 byte builder used by
// the front end of the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  // Field widths
  localparam int CU_W      = 16;
  localparam int BUDGET_W  = 12;
  localparam int MAX_RUN   = 6;   // bytes one code unit can release
  localparam int RUN_CNT_W = 3;

  // Defaults for top-level parameters
  localparam int COUNT_WIDTH_DEF = 12;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Surrogate ranges
  localparam logic [CU_W-1:0] HIGH_SURR_LO = 16'hd800;
  localparam logic [CU_W-1:0] HIGH_SURR_HI = 16'hdbff;
  localparam logic [CU_W-1:0] LOW_SURR_LO  = 16'hdc00;
  localparam logic [CU_W-1:0] LOW_SURR_HI  = 16'hdfff;
  localparam logic [20:0]     SUPP_BASE    = 21'h10000;

  // Encoding thresholds and lead/continuation marks
  localparam logic [20:0] LIM_1B   = 21'h80;
  localparam logic [20:0] LIM_2B   = 21'h800;
  localparam logic [20:0] LIM_3B   = 21'h10000;
  localparam logic [7:0]  LEAD_2B  = 8'hc0;
  localparam logic [7:0]  LEAD_3B  = 8'he0;
  localparam logic [7:0]  LEAD_4B  = 8'hf0;
  localparam logic [7:0]  CONT_TAG = 8'h80;
  localparam logic [7:0]  CONT_MSK = 8'h3f;

  // Input request
  typedef struct packed {
    logic [CU_W-1:0] code_unit;
    logic            last_unit;
  } in_item_t;

  // Result request
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_last;
  } out_item_t;

  // One queue entry: all bytes released by one code unit
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [RUN_CNT_W-1:0]    n_bytes;   // zero marks an empty string end
    logic                    last;
  } run_t;

  // Encoded character
  typedef struct packed {
    logic [3:0][7:0]      b;
    logic [RUN_CNT_W-1:0] len;
  } enc_t;

  function automatic enc_t utf8_encode(logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < LIM_1B) begin
      e.b[0] = cp[7:0];
      e.len  = 3'd1;
    end else if (cp < LIM_2B) begin
      e.b[0] = LEAD_2B | {3'b000, cp[10:6]};
      e.b[1] = CONT_TAG | ({2'b00, cp[5:0]} & CONT_MSK);
      e.len  = 3'd2;
    end else if (cp < LIM_3B) begin
      e.b[0] = LEAD_3B | {4'b0000, cp[15:12]};
      e.b[1] = CONT_TAG | {2'b00, cp[11:6]};
      e.b[2] = CONT_TAG | {2'b00, cp[5:0]};
      e.len  = 3'd3;
    end else begin
      e.b[0] = LEAD_4B | {5'b00000, cp[20:18]};
      e.b[1] = CONT_TAG | {2'b00, cp[17:12]};
      e.b[2] = CONT_TAG | {2'b00, cp[11:6]};
      e.b[3] = CONT_TAG | {2'b00, cp[5:0]};
      e.len  = 3'd4;
    end
    return e;
  endfunction

endpackage

@@ hdl/u16u8_front.sv @@
// ----------------------------------------------------------------------------
// u16u8_front: code unit classifier
// Pairs surrogates, applies the byte budget and packs the bytes of each
// accepted code unit into one queue entry.
// ----------------------------------------------------------------------------
module u16u8_front #(
  parameter int COUNT_WIDTH = u16u8_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  u16u8_pkg::in_item_t                 in_data,
  input  logic                                cfg_wr_en,
  input  logic [u16u8_pkg::BUDGET_W-1:0]      cfg_wr_data,
  input  logic                                q_full,
  output logic                                q_push,
  output u16u8_pkg::run_t                     q_wr_data
);

  localparam int CW   = COUNT_WIDTH;
  localparam int CMPW = (CW + 1 > u16u8_pkg::BUDGET_W) ? CW + 1 : u16u8_pkg::BUDGET_W;

  logic [u16u8_pkg::BUDGET_W-1:0] budget_r;
  logic [9:0]                     pend_high_r, pend_high_nxt;
  logic                           pend_valid_r, pend_valid_nxt;
  logic [CW-1:0]                  emitted_r, emitted_nxt;
  logic                           stopped_r, stopped_nxt;

  // saturating byte count update
  function automatic logic [CW-1:0] sat_add(logic [CW-1:0] cnt,
                                             logic [u16u8_pkg::RUN_CNT_W-1:0] len);
    logic [CW:0] s;
    s = {1'b0, cnt} + (CW+1)'(len);
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  // true if len more bytes exceed a nonzero budget
  function automatic logic over_budget(logic [CW-1:0] cnt,
                                       logic [u16u8_pkg::RUN_CNT_W-1:0] len,
                                       logic [u16u8_pkg::BUDGET_W-1:0] bud);
    logic [CMPW-1:0] s;
    s = CMPW'(cnt) + CMPW'(len);
    return (bud != '0) && (s > CMPW'(bud));
  endfunction

  logic                 accept;
  logic                 is_high, is_low, paired;
  logic [20:0]          a_cp, b_cp;
  u16u8_pkg::enc_t      enc_a, enc_b;
  logic                 a_emit, b_want, b_emit, stop_a;
  logic [CW-1:0]        cnt_a;
  logic [u16u8_pkg::RUN_CNT_W-1:0] off, n_total;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // classify the unit
  assign is_high = (in_data.code_unit >= u16u8_pkg::HIGH_SURR_LO) &&
                   (in_data.code_unit <= u16u8_pkg::HIGH_SURR_HI);
  assign is_low  = (in_data.code_unit >= u16u8_pkg::LOW_SURR_LO) &&
                   (in_data.code_unit <= u16u8_pkg::LOW_SURR_HI);
  assign paired  = pend_valid_r && is_low;

  // first character: the held surrogate, alone or completed
  assign a_cp  = paired ? (21'({pend_high_r, in_data.code_unit[9:0]}) + u16u8_pkg::SUPP_BASE)
                        : {5'b00000, u16u8_pkg::HIGH_SURR_LO[15:10], pend_high_r};
  assign enc_a = u16u8_pkg::utf8_encode(a_cp);

  always_comb begin
    a_emit = pend_valid_r && !stopped_r &&
             !over_budget(emitted_r, enc_a.len, budget_r);
    stop_a = stopped_r || (pend_valid_r && over_budget(emitted_r, enc_a.len, budget_r));
    cnt_a  = a_emit ? sat_add(emitted_r, enc_a.len) : emitted_r;
  end

  // second character: the current unit itself
  assign b_cp  = {5'b00000, in_data.code_unit};
  assign enc_b = u16u8_pkg::utf8_encode(b_cp);

  always_comb begin
    b_want = !paired && !(is_high && !in_data.last_unit);
    b_emit = b_want && !stop_a && !over_budget(cnt_a, enc_b.len, budget_r);
  end

  // pack the released bytes
  always_comb begin
    off     = a_emit ? enc_a.len : '0;
    n_total = off + (b_emit ? enc_b.len : '0);
    q_wr_data         = '0;
    q_wr_data.n_bytes = n_total;
    q_wr_data.last    = in_data.last_unit;
    for (int k = 0; k < 4; k++) begin
      if (a_emit && (3'(k) < enc_a.len)) begin
        q_wr_data.bytes[k] = enc_a.b[k];
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (b_emit && (3'(j) < enc_b.len)) begin
        q_wr_data.bytes[off + 3'(j)] = enc_b.b[j];
      end
    end
  end

  assign q_push = accept && ((n_total != '0) || in_data.last_unit);

  // string state update
  always_comb begin
    pend_high_nxt  = pend_high_r;
    pend_valid_nxt = pend_valid_r;
    emitted_nxt    = emitted_r;
    stopped_nxt    = stopped_r;
    if (accept) begin
      if (in_data.last_unit) begin
        pend_high_nxt  = '0;
        pend_valid_nxt = 1'b0;
        emitted_nxt    = '0;
        stopped_nxt    = 1'b0;
      end else begin
        pend_valid_nxt = !paired && is_high && !stop_a;
        if (!paired && is_high && !stop_a) begin
          pend_high_nxt = in_data.code_unit[9:0];
        end
        emitted_nxt = b_emit ? sat_add(cnt_a, enc_b.len) : cnt_a;
        stopped_nxt = stop_a || (b_want && !b_emit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r     <= '0;
      pend_high_r  <= '0;
      pend_valid_r <= 1'b0;
      emitted_r    <= '0;
      stopped_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        budget_r <= cfg_wr_data;
      end
      pend_high_r  <= pend_high_nxt;
      pend_valid_r <= pend_valid_nxt;
      emitted_r    <= emitted_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

endmodule

@@ hdl/u16u8_queue.sv @@
// ----------------------------------------------------------------------------
// u16u8_queue: entry queue between front and back
// Small FIFO of byte runs; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u16u8_pkg::run_t  wr_data,
  output logic             full,
  input  logic             pop,
  output u16u8_pkg::run_t  rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u16u8_pkg::run_t  mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hdl/u16u8_back.sv @@
// ----------------------------------------------------------------------------
// u16u8_back: byte serializer
// Walks the head entry into the output register, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  u16u8_pkg::run_t       q_rd_data,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u16u8_pkg::out_item_t  out_data
);

  logic [u16u8_pkg::RUN_CNT_W-1:0] idx_r, idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  u16u8_pkg::out_item_t            out_data_r, out_data_nxt;
  logic                            load, run_end, marker;

  assign load    = !q_empty && (!out_valid_r || !out_stall);
  assign marker  = (q_rd_data.n_bytes == '0);
  assign run_end = marker || (idx_r == q_rd_data.n_bytes - 1'b1);
  assign q_pop   = load && run_end;

  // next result from the head entry
  always_comb begin
    out_data_nxt             = out_data_r;
    out_data_nxt.out_byte    = marker ? 8'h00 : q_rd_data.bytes[idx_r];
    out_data_nxt.byte_valid  = !marker;
    out_data_nxt.run_last    = run_end;
    out_data_nxt.string_last = run_end && q_rd_data.last;
  end

  // byte index and output valid
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = run_end ? '0 : idx_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/utf16_to_utf8_encoder.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder: UTF-16 code units in, UTF-8 bytes out
// Input channel (in_valid/in_stall/in_data) takes one code unit per request
// with a last-of-string flag. Output channel (out_valid/out_stall/out_data)
// delivers one UTF-8 byte per request, with run_last on the final byte a
// unit caused and string_last on the final result of the string. A last
// unit that releases nothing yields one result with byte_valid low.
// cfg_wr_en/cfg_wr_data set the per-string byte budget (0 = no limit); the
// whole character is dropped if it does not fit, and the rest of the string
// with it.
// The first byte of an accepted unit is written into the queue and then
// loaded into the output register before out_valid rises.
// Throughput: one output byte per cycle from the back serializer while
// out_stall is low; a unit releases 1 to 6 bytes (1 to 3 typical, 3 for BMP
// text above 0x800), and a held high surrogate releases no byte of its own.
// A queue of QUEUE_DEPTH entries sits between front and back: in_stall rises
// only when it is full, so a stalled receiver backs up into the queue first.
// Reset (rst_n low, synchronous) clears the queue, the held surrogate, the
// byte count and sets the budget to zero.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder #(
  parameter int COUNT_WIDTH = u16u8_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  u16u8_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output u16u8_pkg::out_item_t            out_data,
  input  logic                            cfg_wr_en,
  input  logic [u16u8_pkg::BUDGET_W-1:0]  cfg_wr_data
);

  logic             q_push, q_pop, q_full, q_empty;
  u16u8_pkg::run_t  q_wr_data, q_rd_data;

  // classify and pack
  u16u8_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wr_data  (q_wr_data)
  );

  // decoupling queue
  u16u8_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(q_wr_data),
    .full   (q_full),
    .pop    (q_pop),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  // serialize bytes
  u16u8_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_rd_data(q_rd_data),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
